FILE: hw/rtl/nfcs_pkg.sv
package nfcs_pkg;

  localparam int PAGE_BYTES_DEF      = 2048;
  localparam int PAGES_PER_BLOCK_DEF = 64;
  localparam int QUEUE_DEPTH         = 4;

  typedef enum logic [2:0] {
    F_READ    = 3'd0,
    F_PROG    = 3'd1,
    F_ERASE   = 3'd2,
    F_PBYTE   = 3'd3,
    F_READY   = 3'd4,
    F_FBYTE   = 3'd5,
    F_READID  = 3'd6,
    F_UNUSED  = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    K_SEL    = 4'd0,
    K_DESEL  = 4'd1,
    K_CMD    = 4'd2,
    K_ADDR   = 4'd3,
    K_WDATA  = 4'd4,
    K_STROBE = 4'd5,
    K_WAIT   = 4'd6,
    K_USER   = 4'd7,
    K_DONE   = 4'd8,
    K_ALIGN  = 4'd9,
    K_BAD    = 4'd10
  } kind_t;

  // ops handed from front to back; one op per accepted transaction that causes results
  typedef enum logic [3:0] {
    OP_READ_REQ,
    OP_PROG_REQ,
    OP_ERASE_REQ,
    OP_ALIGN_ERR,
    OP_PBYTE,
    OP_READY,
    OP_FBYTE,
    OP_READ_ID
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [23:0] length;
    logic [7:0]  data_byte;
  } cmd_t;

  localparam logic [7:0] C_READ1  = 8'h00;
  localparam logic [7:0] C_READ2  = 8'h30;
  localparam logic [7:0] C_ERASE1 = 8'h60;
  localparam logic [7:0] C_ERASE2 = 8'hD0;
  localparam logic [7:0] C_PROG1  = 8'h80;
  localparam logic [7:0] C_PROG2  = 8'h10;
  localparam logic [7:0] C_ID     = 8'h90;
  localparam logic [7:0] GOOD_MK  = 8'hFF;

endpackage

FILE: hw/rtl/nfcs_front.sv
// Classifies transactions against the mode and pushes ops for the back end.
module nfcs_front
  import nfcs_pkg::*;
#(
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [31:0] addr,
  input  logic [23:0] length,
  input  logic [7:0]  data_byte,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        q_full
);
  localparam int BLK_LG = $clog2(PAGE_BYTES) + $clog2(PAGES_PER_BLOCK);
  localparam int PG_LG  = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    M_IDLE, M_RD_WAIT, M_RD_DATA, M_PG_DATA, M_PG_WAIT, M_ER_WAIT, M_ID_DATA
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] cur, cur_next;
  logic [23:0] rem, rem_next;
  logic        chk, chk_next;
  logic [2:0]  idc, idc_next;
  logic        emit;
  op_t         op;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && emit;
  assign push_cmd = '{op: op, addr: addr, length: length, data_byte: data_byte};

  // Front mirrors the mode tracking of the back end so it can drop ignored transactions.
  always_comb begin
    logic [31:0] c1;
    logic [23:0] r1;
    mode_next = mode; cur_next = cur; rem_next = rem; chk_next = chk; idc_next = idc;
    emit = 1'b0; op = OP_READY;
    c1 = cur + 32'd1;
    r1 = rem - 24'd1;
    case (func_t'(func))
      F_READ: if (mode == M_IDLE) begin
        emit = 1'b1; op = OP_READ_REQ;
        cur_next = addr; rem_next = length;
        if (length != '0) begin
          mode_next = M_RD_WAIT;
          chk_next = (addr[BLK_LG-1:0] == '0);
        end
      end
      F_PROG: if (mode == M_IDLE) begin
        emit = 1'b1; op = OP_PROG_REQ;
        cur_next = addr; rem_next = length;
        mode_next = (length == '0) ? M_PG_WAIT : M_PG_DATA;
      end
      F_ERASE: if (mode == M_IDLE) begin
        emit = 1'b1;
        if (addr[BLK_LG-1:0] != '0 || length[BLK_LG-1:0] != '0) op = OP_ALIGN_ERR;
        else begin
          op = OP_ERASE_REQ;
          if (length != '0) begin
            cur_next = addr; rem_next = length; mode_next = M_ER_WAIT;
          end
        end
      end
      F_PBYTE: if (mode == M_PG_DATA) begin
        emit = 1'b1; op = OP_PBYTE;
        cur_next = c1; rem_next = r1;
        if (r1 == '0 || c1[PG_LG-1:0] == '0) mode_next = M_PG_WAIT;
      end
      F_READY: begin
        op = OP_READY;
        case (mode)
          M_RD_WAIT: begin emit = 1'b1; mode_next = M_RD_DATA; end
          M_PG_WAIT: begin
            emit = 1'b1;
            mode_next = (rem == '0) ? M_IDLE : M_PG_DATA;
          end
          M_ER_WAIT: begin
            emit = 1'b1;
            rem_next = rem - 24'(PAGE_BYTES * PAGES_PER_BLOCK);
            if (rem_next == '0) mode_next = M_IDLE;
            else cur_next = cur + 32'(PAGE_BYTES * PAGES_PER_BLOCK);
          end
          default: ;
        endcase
      end
      F_FBYTE: begin
        op = OP_FBYTE;
        if (mode == M_RD_DATA) begin
          emit = 1'b1;
          if (chk) begin
            mode_next = M_RD_WAIT;
            if (data_byte != GOOD_MK) begin
              cur_next = cur + 32'(PAGE_BYTES * PAGES_PER_BLOCK);
              chk_next = (cur_next[BLK_LG-1:0] == '0);
            end else chk_next = 1'b0;
          end else begin
            cur_next = c1; rem_next = r1;
            if (r1 == '0) mode_next = M_IDLE;
            else if (c1[PG_LG-1:0] == '0) begin
              mode_next = M_RD_WAIT;
              chk_next = (c1[BLK_LG-1:0] == '0);
            end
          end
        end else if (mode == M_ID_DATA) begin
          emit = 1'b1;
          idc_next = idc + 3'd1;
          if (idc_next >= 3'd5) begin
            idc_next = '0; mode_next = M_IDLE;
          end
        end
      end
      F_READID: if (mode == M_IDLE) begin
        emit = 1'b1; op = OP_READ_ID; idc_next = '0; mode_next = M_ID_DATA;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; cur <= '0; rem <= '0; chk <= 1'b0; idc <= '0;
    end else if (in_valid && in_ready) begin
      mode <= mode_next; cur <= cur_next; rem <= rem_next; chk <= chk_next; idc <= idc_next;
    end
  end
endmodule

FILE: hw/rtl/nfcs_queue.sv
module nfcs_queue
  import nfcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  cmd_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign full      = (cnt == (AW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt != '0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_cmd;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

FILE: hw/rtl/nfcs_back.sv
// Expands one op into its bus cycle sequence, one result per cycle while out_ready is high.
module nfcs_back
  import nfcs_pkg::*;
#(
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [7:0]  bus_byte,
  output logic        last
);
  localparam int BLK_LG = $clog2(PAGE_BYTES) + $clog2(PAGES_PER_BLOCK);
  localparam int PG_LG  = $clog2(PAGE_BYTES);
  localparam logic [31:0] BLK = 32'(PAGE_BYTES * PAGES_PER_BLOCK);

  // sequence step codes
  typedef enum logic [3:0] {
    S_SEL, S_DESEL, S_BAD, S_USER, S_WDATA, S_STROBE, S_DONE, S_ALIGN,
    S_C1, S_COL0, S_COL1, S_ROW0, S_ROW1, S_ROW2, S_C2, S_WAIT
  } step_t;

  // sequence flags
  typedef struct packed {
    logic sel;     // leading select
    logic desel;   // deselect
    logic bad;     // bad skipped
    logic user;    // user byte
    logic wdata;
    logic pclose;  // program close: closing command + wait only
    logic strobe;
    logic done;
    logic align;
    logic hdr;     // cmd1/column/row/cmd2/wait block
    logic hcol;    // header has column bytes
    logic hc2;     // header has closing command + wait
  } seq_t;

  logic        busy;
  seq_t        sq;
  logic [3:0]  pos;
  logic [7:0]  c1, c2, db;
  logic [15:0] col;
  logic [23:0] row;
  logic [3:0]  mode;            // tracks state for seq building
  logic [31:0] cur;
  logic [23:0] rem;
  logic        chk;
  logic [2:0]  idc;
  step_t       st;
  logic        is_last;

  // Decode the registered sequence flags into a step list; pos selects the current step.
  step_t steps [16];
  logic [4:0] nsteps;
  always_comb begin
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) steps[i] = S_DONE;
    if (sq.user)  begin steps[n[3:0]] = S_USER;  n = n + 5'd1; end
    if (sq.wdata) begin steps[n[3:0]] = S_WDATA; n = n + 5'd1; end
    if (sq.pclose) begin
      steps[n[3:0]] = S_C2;   n = n + 5'd1;
      steps[n[3:0]] = S_WAIT; n = n + 5'd1;
    end
    if (sq.strobe && !sq.hdr) begin steps[n[3:0]] = S_STROBE; n = n + 5'd1; end
    if (sq.desel) begin steps[n[3:0]] = S_DESEL; n = n + 5'd1; end
    if (sq.bad)   begin steps[n[3:0]] = S_BAD;   n = n + 5'd1; end
    if (sq.sel)   begin steps[n[3:0]] = S_SEL;   n = n + 5'd1; end
    if (sq.hdr) begin
      steps[n[3:0]] = S_C1; n = n + 5'd1;
      if (sq.hcol) begin
        steps[n[3:0]] = S_COL0; n = n + 5'd1;
        steps[n[3:0]] = S_COL1; n = n + 5'd1;
      end
      if (!sq.strobe) begin
        steps[n[3:0]] = S_ROW0; n = n + 5'd1;
        steps[n[3:0]] = S_ROW1; n = n + 5'd1;
        steps[n[3:0]] = S_ROW2; n = n + 5'd1;
      end else begin
        // read id: a single 00h address cycle
        steps[n[3:0]] = S_COL0; n = n + 5'd1;
      end
      if (sq.hc2) begin
        steps[n[3:0]] = S_C2;   n = n + 5'd1;
        steps[n[3:0]] = S_WAIT; n = n + 5'd1;
      end
      if (sq.strobe) begin steps[n[3:0]] = S_STROBE; n = n + 5'd1; end
    end
    if (sq.done)  begin steps[n[3:0]] = S_DONE;  n = n + 5'd1; end
    if (sq.align) begin steps[n[3:0]] = S_ALIGN; n = n + 5'd1; end
    nsteps = n;
  end

  assign st      = steps[pos];
  assign is_last = (5'(pos) + 5'd1 == nsteps);

  always_comb begin
    bus_byte = '0;
    case (st)
      S_SEL:    kind = K_SEL;
      S_DESEL:  kind = K_DESEL;
      S_BAD:    kind = K_BAD;
      S_USER:   begin kind = K_USER; bus_byte = db; end
      S_WDATA:  begin kind = K_WDATA; bus_byte = db; end
      S_STROBE: kind = K_STROBE;
      S_DONE:   kind = K_DONE;
      S_ALIGN:  kind = K_ALIGN;
      S_C1:     begin kind = K_CMD; bus_byte = c1; end
      S_C2:     begin kind = K_CMD; bus_byte = c2; end
      S_COL0:   begin kind = K_ADDR; bus_byte = col[7:0]; end
      S_COL1:   begin kind = K_ADDR; bus_byte = col[15:8]; end
      S_ROW0:   begin kind = K_ADDR; bus_byte = row[7:0]; end
      S_ROW1:   begin kind = K_ADDR; bus_byte = row[15:8]; end
      S_ROW2:   begin kind = K_ADDR; bus_byte = row[23:16]; end
      S_WAIT:   kind = K_WAIT;
      default:  kind = K_DONE;
    endcase
  end

  assign out_valid = busy;
  assign last      = is_last;
  assign pop       = q_valid && (!busy || (out_ready && is_last));

  localparam logic [3:0] M_IDLE = 4'd0, M_RDW = 4'd1, M_RDD = 4'd2, M_PGD = 4'd3,
                         M_PGW = 4'd4, M_ERW = 4'd5, M_ID = 4'd6;

  // Build the next sequence from the queued op.
  seq_t        nsq;
  logic [7:0]  nc1, nc2;
  logic [15:0] ncol;
  logic [23:0] nrow;
  logic [3:0]  nmode;
  logic [31:0] ncur;
  logic [23:0] nrem;
  logic        nchk;
  logic [2:0]  nidc;

  always_comb begin
    logic [31:0] a;
    logic [31:0] ci;
    logic [23:0] ri;
    logic [2:0]  ii;
    nsq = '0; nc1 = C_READ1; nc2 = C_READ2; ncol = '0; nrow = '0;
    nmode = mode; ncur = cur; nrem = rem; nchk = chk; nidc = idc;
    a = '0; ci = cur + 32'd1; ri = rem - 24'd1; ii = idc + 3'd1;
    case (q_cmd.op)
      OP_READ_REQ: begin
        ncur = q_cmd.addr; nrem = q_cmd.length;
        if (q_cmd.length == '0) nsq.done = 1'b1;
        else begin nsq.sel = 1'b1; a = q_cmd.addr; nsq.hdr = 1'b1; nmode = M_RDW;
          nsq.hcol = 1'b1; nsq.hc2 = 1'b1;
          nchk = (a[BLK_LG-1:0] == '0);
        end
      end
      OP_PROG_REQ: begin
        ncur = q_cmd.addr; nrem = q_cmd.length; a = q_cmd.addr;
        nsq.sel = 1'b1; nsq.hdr = 1'b1; nsq.hcol = 1'b1; nc1 = C_PROG1;
        nc2 = C_PROG2;
        nsq.hc2 = (q_cmd.length == '0);
        nmode = (q_cmd.length == '0) ? M_PGW : M_PGD;
      end
      OP_ERASE_REQ: begin
        if (q_cmd.length == '0) nsq.done = 1'b1;
        else begin
          ncur = q_cmd.addr; nrem = q_cmd.length; a = q_cmd.addr;
          nsq.sel = 1'b1; nsq.hdr = 1'b1; nsq.hc2 = 1'b1;
          nc1 = C_ERASE1; nc2 = C_ERASE2; nmode = M_ERW;
        end
      end
      OP_ALIGN_ERR: nsq.align = 1'b1;
      OP_PBYTE: begin
        nsq.wdata = 1'b1; ncur = ci; nrem = ri;
        if (ri == '0 || ci[PG_LG-1:0] == '0) begin
          nsq.pclose = 1'b1; nc2 = C_PROG2; nmode = M_PGW;
        end
      end
      OP_READY: begin
        case (mode)
          M_RDW: begin nsq.strobe = 1'b1; nmode = M_RDD; end
          M_PGW: if (rem == '0) begin nsq.desel = 1'b1; nsq.done = 1'b1; nmode = M_IDLE; end
                 else begin a = cur; nsq.hdr = 1'b1; nsq.hcol = 1'b1; nc1 = C_PROG1;
                   nmode = M_PGD; end
          M_ERW: begin
            nrem = rem - BLK[23:0];
            if (nrem == '0) begin nsq.desel = 1'b1; nsq.done = 1'b1; nmode = M_IDLE; end
            else begin ncur = cur + BLK; a = ncur; nsq.hdr = 1'b1; nsq.hc2 = 1'b1;
              nc1 = C_ERASE1; nc2 = C_ERASE2; end
          end
          default: ;
        endcase
      end
      OP_FBYTE: begin
        if (mode == M_ID) begin
          nsq.user = 1'b1; nidc = ii;
          if (ii < 3'd5) nsq.strobe = 1'b1;
          else begin nsq.desel = 1'b1; nsq.done = 1'b1; nidc = '0; nmode = M_IDLE; end
        end else if (chk) begin
          nsq.desel = 1'b1; nsq.sel = 1'b1; nsq.hdr = 1'b1; nsq.hcol = 1'b1; nsq.hc2 = 1'b1;
          if (q_cmd.data_byte != GOOD_MK) begin
            nsq.bad = 1'b1; ncur = cur + BLK; a = ncur;
            nchk = (a[BLK_LG-1:0] == '0);
          end else begin a = cur; nchk = 1'b0; end
          nmode = M_RDW;
        end else begin
          nsq.user = 1'b1; ncur = ci; nrem = ri;
          if (ri != '0 && ci[PG_LG-1:0] != '0) nsq.strobe = 1'b1;
          else begin
            nsq.desel = 1'b1;
            if (ri == '0) begin nsq.done = 1'b1; nmode = M_IDLE; end
            else begin a = ci; nsq.sel = 1'b1; nsq.hdr = 1'b1; nsq.hcol = 1'b1;
              nsq.hc2 = 1'b1; nchk = (a[BLK_LG-1:0] == '0); nmode = M_RDW; end
          end
        end
      end
      OP_READ_ID: begin
        nsq.sel = 1'b1; nsq.hdr = 1'b1; nsq.hcol = 1'b0; nsq.strobe = 1'b1;
        nc1 = C_ID; nidc = '0; nmode = M_ID;
      end
      default: ;
    endcase
    ncol = 16'(a[PG_LG-1:0]);
    if (nsq.hdr && nc1 == C_READ1 && nchk && q_cmd.op != OP_PBYTE) ncol = 16'(PAGE_BYTES);
    nrow = 24'(a >> PG_LG);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sq <= nsq;
      c1 <= nc1; c2 <= nc2; db <= q_cmd.data_byte; col <= ncol; row <= nrow;
    end
    if (rst) begin
      busy <= 1'b0; pos <= '0; mode <= M_IDLE; cur <= '0; rem <= '0;
      chk <= 1'b0; idc <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1; pos <= '0; mode <= nmode; cur <= ncur; rem <= nrem;
        chk <= nchk; idc <= nidc;
      end else if (busy && out_ready) begin
        if (is_last) busy <= 1'b0;
        else pos <= pos + 4'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("pop on empty queue");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (5'(pos) < nsteps)) else $error("step past end");
`endif
endmodule

FILE: hw/rtl/nand_flash_command_sequencer.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | func, addr, length, data_byte
// out     | out | out_valid/out_ready| kind, bus_byte, last
// Front takes one transaction per cycle while the 4-entry queue has room.
// Back emits one result per cycle while out_ready is high; a transaction yields 0 to 11 results
// (ignored ones none), the first once the op has been written to the queue and loaded into the
// back end's sequence registers, so the sustained rate is set by the back end's result count.
// Reset (rst, synchronous) empties the queue and returns the mode to idle.
// A stalled output holds the back end; the queue keeps the front accepting until it is full.
module nand_flash_command_sequencer
  import nfcs_pkg::*;
#(
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [31:0] addr,
  input  logic [23:0] length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [7:0]  bus_byte,
  output logic        last
);
  logic push, full, pop, q_valid;
  cmd_t push_cmd, head;

  nfcs_front #(.PAGE_BYTES(PAGE_BYTES), .PAGES_PER_BLOCK(PAGES_PER_BLOCK)) u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .addr, .length, .data_byte,
    .push, .push_cmd, .q_full(full)
  );

  nfcs_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full, .pop, .not_empty(q_valid), .head
  );

  nfcs_back #(.PAGE_BYTES(PAGE_BYTES), .PAGES_PER_BLOCK(PAGES_PER_BLOCK)) u_back (
    .clk, .rst, .q_valid, .q_cmd(head), .pop, .out_valid, .out_ready,
    .kind, .bus_byte, .last
  );
endmodule
